FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define PRLSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prlsd assertion failed");

// Next-cycle implication, reset masked.
`define PRLSD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prlsd assertion failed");

`endif

FILE: rtl/core/prlsd_pkg.sv
package prlsd_pkg;

  localparam int unsigned MAX_PACKETS = 4;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_LONG_HI,
    PH_LONG_LO,
    PH_COLOR,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    MODE_RAW   = 2'd0,
    MODE_PURE  = 2'd1,
    MODE_MIXED = 2'd2,
    MODE_BAD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_PACKET_COUNT = 2'd1,
    REG_PACKET_MASKS = 2'd2,
    REG_PACKET_MODES = 2'd3
  } reg_index_t;

  localparam logic [15:0] LINE_WIDTH_RST   = 16'd1;
  localparam logic [2:0]  PACKET_COUNT_RST = 3'd1;
  localparam logic [15:0] PACKET_MASKS_RST = 16'd240;
  localparam logic [7:0]  PACKET_MODES_RST = 8'd0;

  localparam logic [7:0] LONG_RUN_MARK = 8'h80;
  localparam logic [8:0] SHORT_RUN_BIAS = 9'd127;

  typedef struct packed {
    logic [15:0] x_start;
    logic [15:0] run_length;
    logic [3:0]  component_mask;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [1:0]  packet_index;
    logic        last_in_line;
    logic        error;
  } span_t;

endpackage

FILE: rtl/core/prlsd_channels.sv
interface prlsd_stream_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface prlsd_span_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_start;
  logic [15:0] run_length;
  logic [3:0]  component_mask;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [1:0]  packet_index;
  logic        last_in_line;
  logic        error;

  modport source (
    output valid, x_start, run_length, component_mask, red, green, blue, alpha,
           packet_index, last_in_line, error,
    input  ready
  );
  modport sink (
    input  valid, x_start, run_length, component_mask, red, green, blue, alpha,
           packet_index, last_in_line, error,
    output ready
  );
endinterface

interface prlsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pic_run_length_scanline_decoder.sv
// channel  dir  word                              handshake
// stream   in   command, data_byte                valid/ready
// span     out  x_start .. error (one span)       valid/ready
// cfg      in   index, data (register write)      valid/ready, ready always high
//
// One compressed byte per cycle while stream.ready is high; a byte is decoded in the cycle it is taken.
// A span from a taken byte is registered into the output register, or into the skid register if the head stalls.
// A skid register behind the output holds one more span while the head stalls;
// stream.ready drops only while that skid register is full.
// Reset is synchronous; decoder state, config and output queue clear at once.
module pic_run_length_scanline_decoder import prlsd_pkg::*; (
  input logic          clk,
  input logic          rst,
  prlsd_stream_if.sink stream,
  prlsd_span_if.source span,
  prlsd_cfg_if.sink    cfg
);

  logic [15:0] line_width;
  logic [2:0]  packet_count;
  logic [15:0] packet_masks;
  logic [7:0]  packet_modes;

  phase_t      phase, phase_next;
  logic [15:0] column, column_next;
  logic [1:0]  pkt, pkt_next;
  logic [15:0] pend, pend_next;
  logic [1:0]  slot, slot_next;
  logic        rep, rep_next;
  logic [7:0]  latch [4];
  logic [7:0]  latch_next [4];

  span_t res, head, skid;
  logic  res_valid, head_valid, skid_valid;
  logic  accept, head_load;

  assign accept       = stream.valid && stream.ready;
  assign stream.ready = !skid_valid;
  assign cfg.ready    = 1'b1;
  assign head_load    = !head_valid || span.ready;

  always_comb begin
    logic [15:0] w, rest, n, run_n, len;
    logic [3:0]  m;
    mode_t       mode;
    logic [2:0]  nc, effc, run_nc, seen;
    logic [8:0]  sn;
    logic [7:0]  b;
    logic [16:0] end_sum;
    logic [1:0]  s1;
    logic        run_go, run_rep, do_comp, do_fail, do_emit, last, ended, stored;

    phase_next = phase;
    column_next = column;
    pkt_next = pkt;
    pend_next = pend;
    slot_next = slot;
    rep_next = rep;
    latch_next = latch;
    res = '0;
    res_valid = 1'b0;

    b = stream.data_byte;
    w = (line_width == 16'd0) ? 16'd1 : line_width;
    if (packet_count == 3'd0) begin
      effc = 3'd1;
    end else if (packet_count > 3'(MAX_PACKETS)) begin
      effc = 3'(MAX_PACKETS);
    end else begin
      effc = packet_count;
    end
    m = packet_masks[{pkt, 2'b00} +: 4];
    mode = mode_t'(packet_modes[{pkt, 1'b0} +: 2]);
    nc = 3'($countones(m));
    rest = w - column;
    last = ({1'b0, pkt} + 3'd1) >= effc;

    n = '0;
    sn = '0;
    run_n = '0;
    run_nc = '0;
    run_go = 1'b0;
    run_rep = 1'b0;
    do_comp = 1'b0;
    do_fail = 1'b0;
    do_emit = 1'b0;
    len = '0;
    seen = '0;
    stored = 1'b0;
    s1 = '0;
    end_sum = '0;
    ended = 1'b0;

    if (accept) begin
      if (stream.command) begin
        column_next = '0;
        pkt_next = '0;
        phase_next = PH_COUNT;
        slot_next = '0;
        pend_next = '0;
        rep_next = 1'b0;
      end else if (phase != PH_HALT) begin
        if (mode == MODE_BAD || (mode == MODE_RAW && nc == 3'd0) || column >= w) begin
          do_fail = 1'b1;
        end else begin
          unique case (phase)
            PH_COUNT: begin
              if (mode == MODE_RAW) begin
                rep_next = 1'b0;
                pend_next = '0;
                slot_next = '0;
                do_comp = 1'b1;
              end else if (mode == MODE_PURE) begin
                run_go = 1'b1;
                run_n = ({8'd0, b} < rest) ? {8'd0, b} : rest;
                run_rep = 1'b1;
                run_nc = nc;
              end else if (b == LONG_RUN_MARK) begin
                phase_next = PH_LONG_HI;
              end else begin
                sn = (b > LONG_RUN_MARK) ? ({1'b0, b} - SHORT_RUN_BIAS)
                                         : ({1'b0, b} + 9'd1);
                n = {7'd0, sn};
                if (n > rest) begin
                  do_fail = 1'b1;
                end else begin
                  run_go = 1'b1;
                  run_n = n;
                  run_rep = (b > LONG_RUN_MARK);
                  run_nc = nc;
                end
              end
            end
            PH_LONG_HI: begin
              pend_next = {b, 8'h00};
              phase_next = PH_LONG_LO;
            end
            PH_LONG_LO: begin
              n = {pend[15:8], b};
              if (n > rest) begin
                do_fail = 1'b1;
              end else begin
                run_go = 1'b1;
                run_n = n;
                run_rep = 1'b1;
                run_nc = (nc == 3'd0 && n == 16'd0) ? 3'd1 : nc;
              end
            end
            default: do_comp = 1'b1;
          endcase
        end
      end
    end

    if (run_go) begin
      rep_next = run_rep;
      pend_next = run_n;
      slot_next = '0;
      if (run_nc == 3'd0) begin
        phase_next = PH_COUNT;
        pend_next = '0;
        do_emit = (run_n != 16'd0);
        len = run_n;
      end else begin
        phase_next = PH_COLOR;
      end
    end

    if (do_comp) begin
      if ({1'b0, slot_next} < nc) begin
        for (int c = 0; c < 4; c++) begin
          if (m[3-c]) begin
            if (seen == {1'b0, slot_next} && !stored) begin
              latch_next[c] = b;
              stored = 1'b1;
            end
            seen = seen + 3'd1;
          end
        end
      end
      s1 = slot_next + 2'd1;
      if (s1 == 2'd0 || {1'b0, s1} >= nc) begin
        slot_next = '0;
        if (rep_next) begin
          phase_next = PH_COUNT;
          do_emit = (pend_next != 16'd0);
          len = pend_next;
          pend_next = '0;
        end else begin
          n = (pend_next != 16'd0) ? pend_next - 16'd1 : 16'd0;
          phase_next = (n != 16'd0 && mode != MODE_RAW) ? PH_COLOR : PH_COUNT;
          pend_next = (mode == MODE_RAW) ? 16'd0 : n;
          do_emit = 1'b1;
          len = 16'd1;
        end
      end else begin
        slot_next = s1;
        phase_next = PH_COLOR;
      end
    end

    if (do_emit) begin
      end_sum = {1'b0, column} + {1'b0, len};
      ended = end_sum >= {1'b0, w};
      res_valid = 1'b1;
      res.x_start = column;
      res.run_length = len;
      res.component_mask = m;
      res.red = m[3] ? latch_next[0] : 8'd0;
      res.green = m[2] ? latch_next[1] : 8'd0;
      res.blue = m[1] ? latch_next[2] : 8'd0;
      res.alpha = m[0] ? latch_next[3] : 8'd0;
      res.packet_index = pkt;
      res.last_in_line = ended && last;
      res.error = 1'b0;
      column_next = end_sum[15:0];
      if (ended) begin
        pkt_next = last ? 2'd0 : pkt + 2'd1;
        column_next = '0;
        phase_next = PH_COUNT;
        slot_next = '0;
        pend_next = '0;
        rep_next = 1'b0;
      end
    end

    if (do_fail) begin
      res_valid = 1'b1;
      res.x_start = column;
      res.component_mask = m;
      res.packet_index = pkt;
      res.error = 1'b1;
      phase_next = PH_HALT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
      packet_count <= PACKET_COUNT_RST;
      packet_masks <= PACKET_MASKS_RST;
      packet_modes <= PACKET_MODES_RST;
      phase <= PH_COUNT;
      column <= '0;
      pkt <= '0;
      pend <= '0;
      slot <= '0;
      rep <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        latch[i] <= '0;
      end
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (reg_index_t'(cfg.index))
          REG_LINE_WIDTH:   line_width <= cfg.data;
          REG_PACKET_COUNT: packet_count <= cfg.data[2:0];
          REG_PACKET_MASKS: packet_masks <= cfg.data;
          REG_PACKET_MODES: packet_modes <= cfg.data[7:0];
        endcase
      end
      phase <= phase_next;
      column <= column_next;
      pkt <= pkt_next;
      pend <= pend_next;
      slot <= slot_next;
      rep <= rep_next;
      latch <= latch_next;
      if (head_load) begin
        head_valid <= skid_valid || res_valid;
        skid_valid <= 1'b0;
      end else if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_load) begin
      head <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  assign span.valid = head_valid;
  assign span.x_start = head.x_start;
  assign span.run_length = head.run_length;
  assign span.component_mask = head.component_mask;
  assign span.red = head.red;
  assign span.green = head.green;
  assign span.blue = head.blue;
  assign span.alpha = head.alpha;
  assign span.packet_index = head.packet_index;
  assign span.last_in_line = head.last_in_line;
  assign span.error = head.error;

endmodule

FILE: rtl/core/prlsd_checker.sv
`include "assert_macros.svh"

module prlsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        stream_ready,
  input logic        span_valid,
  input logic        span_ready,
  input logic [15:0] span_x_start,
  input logic [15:0] span_run_length,
  input logic        span_last_in_line,
  input logic        span_error
);

  // stalled span holds its word
  `PRLSD_ASSERT_NXT(a_span_hold, clk, rst, span_valid && !span_ready,
    span_valid && $stable(span_x_start) && $stable(span_run_length) && $stable(span_error))

  // input stalls only behind a stalled span
  `PRLSD_ASSERT_IMP(a_backpressure, clk, rst, !stream_ready,
    $past(span_valid) && !$past(span_ready))

  // a span that closes a line is followed by one starting at column zero
  `PRLSD_ASSERT_NXT(a_line_wrap, clk, rst,
    span_valid && span_ready && !span_error && span_last_in_line,
    !span_valid || span_x_start == 16'd0)

endmodule

bind pic_run_length_scanline_decoder prlsd_checker u_prlsd_checker (
  .clk               (clk),
  .rst               (rst),
  .stream_ready      (stream.ready),
  .span_valid        (span.valid),
  .span_ready        (span.ready),
  .span_x_start      (span.x_start),
  .span_run_length   (span.run_length),
  .span_last_in_line (span.last_in_line),
  .span_error        (span.error)
);

FILE: bench/tb_pic_run_length_scanline_decoder.sv
`timescale 1ns / 100ps

module tb_pic_run_length_scanline_decoder;
  import prlsd_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [7:0] b;
  } stream_word_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_off = 1'b0;

  prlsd_stream_if stream_ch();
  prlsd_span_if   span_ch();
  prlsd_cfg_if    cfg_ch();

  pic_run_length_scanline_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .stream(stream_ch),
    .span  (span_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register mirror
  logic [15:0] cfg_width;
  logic [2:0]  cfg_count;
  logic [15:0] cfg_masks;
  logic [7:0]  cfg_modes;

  // decoder state mirror
  phase_t      ph;
  logic [15:0] col;
  logic [1:0]  pkt;
  logic [15:0] pend;
  logic [1:0]  slot;
  logic [7:0]  latch [4];
  logic        rep;
  logic        err_halt;

  stream_word_t words_out [$];
  span_t        spans_due [$];
  int           words_left = 0;
  int           accepted = 0;
  int           mismatches = 0;
  int           phase_items = 0;
  int           budget = 0;
  bit           calm = 1'b0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;

  function automatic int eff_width();
    return (cfg_width == 16'd0) ? 1 : int'(cfg_width);
  endfunction

  function automatic int eff_packets();
    if (cfg_count == 3'd0) return 1;
    if (cfg_count > MAX_PACKETS) return MAX_PACKETS;
    return int'(cfg_count);
  endfunction

  function automatic logic [3:0] mask_of(logic [1:0] k);
    return cfg_masks[k*4 +: 4];
  endfunction

  function automatic mode_t mode_of(logic [1:0] k);
    return mode_t'(cfg_modes[k*2 +: 2]);
  endfunction

  function automatic void new_packet();
    ph = PH_COUNT;
    slot = 2'd0;
    pend = 16'd0;
    rep = 1'b0;
  endfunction

  function automatic span_t run_span(int len);
    span_t      s;
    logic [3:0] m;
    bit         ended;
    bit         last_pkt;
    m = mask_of(pkt);
    last_pkt = (int'(pkt) + 1) >= eff_packets();
    ended = (int'(col) + len) >= eff_width();
    s = '0;
    s.x_start = col;
    s.run_length = 16'(len);
    s.component_mask = m;
    s.red = m[3] ? latch[0] : 8'd0;
    s.green = m[2] ? latch[1] : 8'd0;
    s.blue = m[1] ? latch[2] : 8'd0;
    s.alpha = m[0] ? latch[3] : 8'd0;
    s.packet_index = pkt;
    s.last_in_line = ended && last_pkt;
    col = col + 16'(len);
    if (ended) begin
      pkt = last_pkt ? 2'd0 : pkt + 2'd1;
      col = 16'd0;
      new_packet();
    end
    return s;
  endfunction

  function automatic span_t error_span();
    span_t s;
    s = '0;
    s.x_start = col;
    s.component_mask = mask_of(pkt);
    s.packet_index = pkt;
    s.error = 1'b1;
    err_halt = 1'b1;
    ph = PH_HALT;
    return s;
  endfunction

  // count decoded: either gather its components or give the span now
  function automatic bit begin_run(int n, bit r, int ncomp, output span_t s);
    rep = r;
    pend = 16'(n);
    slot = 2'd0;
    if (ncomp == 0) begin
      ph = PH_COUNT;
      pend = 16'd0;
      if (n == 0) return 1'b0;
      s = run_span(n);
      return 1'b1;
    end
    ph = PH_COLOR;
    return 1'b0;
  endfunction

  task automatic decode_word(input logic cmd, input logic [7:0] b);
    int         w;
    int         rest;
    int         n;
    int         nc;
    int         seen;
    logic [3:0] m;
    mode_t      md;
    span_t      s;
    bit         got;
    bit         comp_byte;
    got = 1'b0;
    comp_byte = 1'b0;
    if (cmd) begin
      err_halt = 1'b0;
      col = 16'd0;
      pkt = 2'd0;
      new_packet();
      return;
    end
    if (ph == PH_HALT || err_halt) return;
    w = eff_width();
    m = mask_of(pkt);
    md = mode_of(pkt);
    nc = $countones(m);
    if (md == MODE_BAD || (md == MODE_RAW && nc == 0) || int'(col) >= w) begin
      spans_due.push_back(error_span());
      return;
    end
    rest = w - int'(col);
    case (ph)
      PH_COUNT: begin
        if (md == MODE_RAW) begin
          rep = 1'b0;
          pend = 16'd0;
          slot = 2'd0;
          comp_byte = 1'b1;
        end else if (md == MODE_PURE) begin
          got = begin_run((int'(b) < rest) ? int'(b) : rest, 1'b1, nc, s);
        end else if (b == LONG_RUN_MARK) begin
          ph = PH_LONG_HI;
        end else begin
          n = (b > LONG_RUN_MARK) ? int'(b) - int'(SHORT_RUN_BIAS) : int'(b) + 1;
          if (n > rest) begin
            s = error_span();
            got = 1'b1;
          end else begin
            got = begin_run(n, b > LONG_RUN_MARK, nc, s);
          end
        end
      end
      PH_LONG_HI: begin
        pend = {b, 8'h00};
        ph = PH_LONG_LO;
      end
      PH_LONG_LO: begin
        n = int'({pend[15:8], b});
        if (n > rest) begin
          s = error_span();
          got = 1'b1;
        end else begin
          got = begin_run(n, 1'b1, (nc == 0 && n == 0) ? 1 : nc, s);
        end
      end
      default: comp_byte = 1'b1;
    endcase
    if (comp_byte) begin
      if (int'(slot) < nc) begin
        seen = 0;
        for (int c = 0; c < 4; c++) begin
          if (m[3-c]) begin
            if (seen == int'(slot)) latch[c] = b;
            seen++;
          end
        end
      end
      slot = slot + 2'd1;
      if (slot == 2'd0 || int'(slot) >= nc) begin
        slot = 2'd0;
        if (rep) begin
          n = int'(pend);
          ph = PH_COUNT;
          pend = 16'd0;
          if (n != 0) begin
            s = run_span(n);
            got = 1'b1;
          end
        end else begin
          if (pend != 16'd0) pend--;
          ph = (pend != 16'd0 && md != MODE_RAW) ? PH_COLOR : PH_COUNT;
          if (md == MODE_RAW) pend = 16'd0;
          s = run_span(1);
          got = 1'b1;
        end
      end else begin
        ph = PH_COLOR;
      end
    end
    if (got) spans_due.push_back(s);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic cmd, input logic [7:0] b);
    words_out.push_back('{cmd: cmd, b: b});
    words_left++;
    phase_items++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic put_reg(input reg_index_t idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic write_config(input logic [15:0] w, input logic [2:0] cnt,
                              input logic [15:0] masks, input logic [7:0] modes);
    put_reg(REG_LINE_WIDTH, w);
    put_reg(REG_PACKET_COUNT, {13'd0, cnt});
    put_reg(REG_PACKET_MASKS, masks);
    put_reg(REG_PACKET_MODES, {8'd0, modes});
    cfg_ch.valid <= 1'b0;
    cfg_width = w;
    cfg_count = cnt;
    cfg_masks = masks;
    cfg_modes = modes;
  endtask

  task automatic wait_idle();
    int cycles;
    cycles = 0;
    do begin
      @(posedge clk);
      cycles++;
    end while ((words_left != 0 || spans_due.size() != 0) && cycles < 50000);
    if (words_left != 0 || spans_due.size() != 0) begin
      $error("%0d expected spans never arrived, %0d words unsent",
             spans_due.size(), words_left);
      mismatches++;
      spans_due.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // one scanline of well-formed packets for the current registers, with
  // an occasional overrun, broken packet or noise
  task automatic queue_scanline();
    int         w;
    int         np;
    int         cx;
    int         rest;
    int         n;
    int         nc;
    int         r;
    logic [3:0] m;
    mode_t      md;
    w = eff_width();
    np = eff_packets();
    for (int p = 0; p < np && phase_items < budget; p++) begin
      m = mask_of(2'(p));
      md = mode_of(2'(p));
      nc = $countones(m);
      cx = 0;
      if (md == MODE_BAD || (md == MODE_RAW && nc == 0)) begin
        send_byte(1'b0, any_byte());
        send_byte(1'b1, any_byte());
        return;
      end
      while (cx < w && phase_items < budget) begin
        rest = w - cx;
        case (md)
          MODE_RAW: begin
            repeat (nc) send_byte(1'b0, any_byte());
            cx++;
          end
          MODE_PURE: begin
            if ($urandom_range(0, 15) == 0) n = $urandom_range(0, 255);
            else n = $urandom_range(1, (rest < 255) ? rest : 255);
            send_byte(1'b0, 8'(n));
            repeat (nc) send_byte(1'b0, any_byte());
            cx += (n < rest) ? n : rest;
          end
          default: begin
            r = $urandom_range(0, 99);
            if (r < 5 && rest < 65535) begin
              n = rest + 1;
              if (rest < 128) begin
                send_byte(1'b0, 8'(n - 1));
              end else begin
                send_byte(1'b0, LONG_RUN_MARK);
                send_byte(1'b0, 8'(n >> 8));
                send_byte(1'b0, 8'(n));
              end
              send_byte(1'b1, any_byte());
              return;
            end else if (r < 80 && r >= 45 && rest >= 2) begin
              n = $urandom_range(2, (rest < 128) ? rest : 128);
              send_byte(1'b0, 8'(n + int'(SHORT_RUN_BIAS)));
              repeat (nc) send_byte(1'b0, any_byte());
              cx += n;
            end else if (r >= 80) begin
              n = $urandom_range(0, rest);
              send_byte(1'b0, LONG_RUN_MARK);
              send_byte(1'b0, 8'(n >> 8));
              send_byte(1'b0, 8'(n));
              repeat ((nc == 0 && n == 0) ? 1 : nc) send_byte(1'b0, any_byte());
              cx += n;
            end else begin
              n = $urandom_range(1, (rest < 8) ? rest : 8);
              send_byte(1'b0, 8'(n - 1));
              repeat (n * nc) send_byte(1'b0, any_byte());
              cx += n;
            end
          end
        endcase
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) send_byte($urandom_range(0, 7) == 0, any_byte());
    end
  endtask

  always @(posedge clk) begin
    stream_word_t nxt;
    bit busy;
    if (rst) begin
      stream_ch.valid <= 1'b0;
      stream_ch.command <= 1'b0;
      stream_ch.data_byte <= 8'd0;
      gap_left = 0;
    end else begin
      busy = stream_ch.valid;
      if (stream_ch.valid && stream_ch.ready) begin
        decode_word(stream_ch.command, stream_ch.data_byte);
        accepted++;
        words_left--;
        busy = 1'b0;
        gap_left = pick_gap();
      end
      if (!busy) begin
        if (gap_left != 0) begin
          gap_left--;
          stream_ch.valid <= 1'b0;
        end else if (words_out.size() != 0) begin
          nxt = words_out.pop_front();
          stream_ch.valid <= 1'b1;
          stream_ch.command <= nxt.cmd;
          stream_ch.data_byte <= nxt.b;
        end else begin
          stream_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    span_t want;
    if (rst) begin
      span_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (span_ch.valid && span_ch.ready) begin
        if (spans_due.size() == 0) begin
          $error("unexpected span at x_start %0d", span_ch.x_start);
          mismatches++;
        end else begin
          want = spans_due.pop_front();
          check_field("x_start", want.x_start, span_ch.x_start);
          check_field("run_length", want.run_length, span_ch.run_length);
          check_field("component_mask", want.component_mask, span_ch.component_mask);
          check_field("red", want.red, span_ch.red);
          check_field("green", want.green, span_ch.green);
          check_field("blue", want.blue, span_ch.blue);
          check_field("alpha", want.alpha, span_ch.alpha);
          check_field("packet_index", want.packet_index, span_ch.packet_index);
          check_field("last_in_line", want.last_in_line, span_ch.last_in_line);
          check_field("error", want.error, span_ch.error);
        end
        stall_left = pick_gap();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      span_ch.ready <= (stall_left == 0) && !hold_off;
    end
  end

  // long output stall while input words keep coming
  initial begin
    do @(posedge clk); while (accepted < 200 || words_left < 30);
    hold_off <= 1'b1;
    repeat (120) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          random_items;
    int unsigned r;
    logic [15:0] w;
    logic [15:0] masks;
    logic [7:0]  modes;
    rst = 1'b1;
    stream_ch.valid = 1'b0;
    stream_ch.command = 1'b0;
    stream_ch.data_byte = 8'd0;
    span_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LINE_WIDTH;
    cfg_ch.data = 16'd0;
    cfg_width = LINE_WIDTH_RST;
    cfg_count = PACKET_COUNT_RST;
    cfg_masks = PACKET_MASKS_RST;
    cfg_modes = PACKET_MODES_RST;
    col = 16'd0;
    pkt = 2'd0;
    err_halt = 1'b0;
    for (int c = 0; c < 4; c++) latch[c] = 8'd0;
    new_packet();
    random_items = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset registers: raw packet with empty mask, then halted, then restart
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'h00);
    wait_idle();

    // width 2, packets: raw RGBA, pure R, mixed empty, mixed GA
    write_config(16'd2, 3'd4, 16'h508F,
                 {MODE_MIXED, MODE_MIXED, MODE_PURE, MODE_RAW});
    send_byte(1'b0, 8'h00); send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00); send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hFF); send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF); send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h00); send_byte(1'b0, 8'h5A);
    send_byte(1'b0, 8'hFF); send_byte(1'b0, 8'hA5);
    send_byte(1'b0, LONG_RUN_MARK); send_byte(1'b0, 8'h00); send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h33);
    send_byte(1'b0, 8'h81);
    send_byte(1'b0, 8'h7F);
    send_byte(1'b1, 8'hFF);
    wait_idle();

    while (random_items < 700) begin
      r = $urandom_range(0, 19);
      case (r)
        0: w = 16'd0;
        1: w = 16'd1;
        2: w = 16'hFFFF;
        3: w = 16'($urandom_range(100, 3000));
        default: w = 16'($urandom_range(1, 10));
      endcase
      r = $urandom_range(0, 9);
      masks = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 : 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 9);
      if (r == 0) modes = {MODE_BAD, MODE_BAD, MODE_BAD, MODE_BAD};
      else if (r == 1) modes = {MODE_RAW, MODE_RAW, MODE_RAW, MODE_RAW};
      else begin
        for (int i = 0; i < 4; i++) begin
          modes[i*2 +: 2] = ($urandom_range(0, 9) == 0) ? MODE_BAD
                                                         : mode_t'($urandom_range(0, 2));
        end
      end
      write_config(w, 3'($urandom_range(0, 7)), masks, modes);
      calm = ($urandom_range(0, 3) == 0);
      phase_items = 0;
      budget = $urandom_range(30, 110);
      if ($urandom_range(0, 9) < 8) send_byte(1'b1, any_byte());
      while (phase_items < budget) queue_scanline();
      random_items += phase_items;
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
